/* rtl/rpi_pkg.sv */
// Shared types and constants for the ray/plane intersection block.
// Used by rpi_div_pipe and ray_plane_intersection_top; depends on nothing.
package rpi_pkg;

  localparam int COORD_W = 32;
  localparam int SIDE_W  = 6 * COORD_W;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_X  = 3'd0,
    REG_POINT_Y  = 3'd1,
    REG_POINT_Z  = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5
  } cfg_reg_t;

  // Control bits that travel with every request through the pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
    logic ovf;
  } ctl_t;

endpackage

/* rtl/rpi_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on rpi_pkg for the control struct and the side payload width.
module rpi_div_pipe import rpi_pkg::*; #(
  parameter int QB_W = 50
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  ctl_t              in_ctl,
  input  logic [64:0]       in_den,
  input  logic [64:0]       in_rem,
  input  logic [QB_W-1:0]   in_sh,
  input  logic [SIDE_W-1:0] in_side,
  output ctl_t              out_ctl,
  output logic [QB_W-1:0]   out_q,
  output logic [SIDE_W-1:0] out_side
);

  ctl_t              ctl_r  [1:QB_W];
  logic [64:0]       den_r  [1:QB_W];
  logic [64:0]       rem_r  [1:QB_W];
  logic [QB_W-1:0]   sh_r   [1:QB_W];
  logic [SIDE_W-1:0] side_r [1:QB_W];

  for (genvar s = 0; s < QB_W; s++) begin : g_stg
    ctl_t              src_ctl;
    logic [64:0]       src_den;
    logic [64:0]       src_rem;
    logic [QB_W-1:0]   src_sh;
    logic [SIDE_W-1:0] src_side;
    logic [65:0]       trial;
    logic [66:0]       dif;

    if (s == 0) begin : g_first
      assign src_ctl  = in_ctl;
      assign src_den  = in_den;
      assign src_rem  = in_rem;
      assign src_sh   = in_sh;
      assign src_side = in_side;
    end else begin : g_next
      assign src_ctl  = ctl_r[s];
      assign src_den  = den_r[s];
      assign src_rem  = rem_r[s];
      assign src_sh   = sh_r[s];
      assign src_side = side_r[s];
    end

    // The top dividend bit is shifted into the partial remainder each step.
    assign trial = {src_rem, src_sh[QB_W-1]};
    assign dif   = {1'b0, trial} - {2'b00, src_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[s+1] <= '0;
      end else if (en) begin
        ctl_r[s+1] <= src_ctl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[s+1]  <= src_den;
        side_r[s+1] <= src_side;
        if (!dif[66]) begin
          rem_r[s+1] <= dif[64:0];
          sh_r[s+1]  <= {src_sh[QB_W-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= trial[64:0];
          sh_r[s+1]  <= {src_sh[QB_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_ctl  = ctl_r[QB_W];
  assign out_q    = sh_r[QB_W];
  assign out_side = side_r[QB_W];

endmodule

/* rtl/ray_plane_intersection_top.sv */
// Ray against a fixed plane in signed fixed point, fully pipelined.
// Depends on rpi_pkg and rpi_div_pipe.
//
// Usage: each request on the in_ channel carries a ray origin and direction.
// The plane is given by a point and a normal written over the cfg_ port
// (index 0..5: point x,y,z then normal x,y,z); cfg_ready is always high. The
// user must make writes only while no request is in flight; not enforced.
// Every request yields exactly one result on the out_ channel: hit, the ray
// parameter t_hit and the hit point, or all zeros on a miss.
// From acceptance to out_valid a request passes four front stages for the
// dot products, one divider stage per quotient bit (FRAC_BITS + 34 of them)
// and three stages for the hit point, the last being the output register.
// Throughput is one request per cycle while out_stall does not hold it.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset (synchronous, rst_n low) clears all valid bits and returns the plane
// to the point at the origin with normal +z.
module ray_plane_intersection_top import rpi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  in_origin_x,
  input  logic signed [COORD_W-1:0]  in_origin_y,
  input  logic signed [COORD_W-1:0]  in_origin_z,
  input  logic signed [COORD_W-1:0]  in_dir_x,
  input  logic signed [COORD_W-1:0]  in_dir_y,
  input  logic signed [COORD_W-1:0]  in_dir_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_hit,
  output logic [30:0]                out_t_hit,
  output logic signed [COORD_W-1:0]  out_hit_x,
  output logic signed [COORD_W-1:0]  out_hit_y,
  output logic signed [COORD_W-1:0]  out_hit_z,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]         cfg_data
);

  localparam int QB   = FRAC_BITS + 34;   // quotient bits kept
  localparam int HALF = (QB + 1) / 2;     // split point of t for the multiply
  localparam int MW   = QB + 32;          // |dir| * t magnitude
  localparam int SW   = MW + 1;           // signed product
  localparam int XW   = SW - FRAC_BITS + 1;

  logic adv;

  // Configuration registers.
  logic signed [COORD_W-1:0] pt_r [3];
  logic signed [COORD_W-1:0] nrm_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r[0]  <= '0;
      pt_r[1]  <= '0;
      pt_r[2]  <= '0;
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= COORD_W'(1) << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_POINT_X:  pt_r[0]  <= cfg_data;
        REG_POINT_Y:  pt_r[1]  <= cfg_data;
        REG_POINT_Z:  pt_r[2]  <= cfg_data;
        REG_NORMAL_X: nrm_r[0] <= cfg_data;
        REG_NORMAL_Y: nrm_r[1] <= cfg_data;
        REG_NORMAL_Z: nrm_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless a finished result is held.
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  logic signed [COORD_W-1:0] org_in [3];
  logic signed [COORD_W-1:0] dir_in [3];
  assign org_in[0] = in_origin_x;
  assign org_in[1] = in_origin_y;
  assign org_in[2] = in_origin_z;
  assign dir_in[0] = in_dir_x;
  assign dir_in[1] = in_dir_y;
  assign dir_in[2] = in_dir_z;

  // Stage 1: point minus origin.
  logic                      v1_r;
  logic signed [32:0]        diff1_r [3];
  logic signed [COORD_W-1:0] org1_r [3];
  logic signed [COORD_W-1:0] dir1_r [3];

  // Stage 2: the six products.
  logic                      v2_r;
  logic signed [64:0]        pn2_r [3];
  logic signed [63:0]        dn2_r [3];
  logic signed [COORD_W-1:0] org2_r [3];
  logic signed [COORD_W-1:0] dir2_r [3];

  // Stage 3: sums and the hit test.
  logic                      v3_r;
  logic                      hit3_r;
  logic [65:0]               num3_r;
  logic [64:0]               den3_r;
  logic signed [COORD_W-1:0] org3_r [3];
  logic signed [COORD_W-1:0] dir3_r [3];

  logic signed [66:0] num_sum;
  logic signed [65:0] den_sum;

  assign num_sum = 67'(pn2_r[0]) + 67'(pn2_r[1]) + 67'(pn2_r[2]);
  assign den_sum = 66'(dn2_r[0]) + 66'(dn2_r[1]) + 66'(dn2_r[2]);

  // Stage 4: divider setup.
  ctl_t              ctl4_r;
  logic [64:0]       den4_r;
  logic [64:0]       rem4_r;
  logic [QB-1:0]     sh4_r;
  logic [SIDE_W-1:0] side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      ctl4_r <= '0;
    end else if (adv) begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      ctl4_r.valid <= v3_r;
      ctl4_r.hit   <= hit3_r;
      // A quotient of 2^QB or more is forced to all ones, saturating t_hit.
      ctl4_r.ovf   <= {33'd0, num3_r[65:34]} >= den3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        diff1_r[k] <= 33'(pt_r[k]) - 33'(org_in[k]);
        org1_r[k]  <= org_in[k];
        dir1_r[k]  <= dir_in[k];
        pn2_r[k]   <= diff1_r[k] * 65'(nrm_r[k]);
        dn2_r[k]   <= dir1_r[k] * 64'(nrm_r[k]);
        org2_r[k]  <= org1_r[k];
        dir2_r[k]  <= dir1_r[k];
        org3_r[k]  <= org2_r[k];
        dir3_r[k]  <= dir2_r[k];
      end
      hit3_r  <= (den_sum > 66'sd0) && !num_sum[66];
      num3_r  <= num_sum[65:0];
      den3_r  <= den_sum[64:0];
      den4_r  <= den3_r;
      rem4_r  <= {33'd0, num3_r[65:34]};
      sh4_r   <= {num3_r[33:0], {FRAC_BITS{1'b0}}};
      side4_r <= {org3_r[0], org3_r[1], org3_r[2], dir3_r[0], dir3_r[1], dir3_r[2]};
    end
  end

  ctl_t              dctl;
  logic [QB-1:0]     dq;
  logic [SIDE_W-1:0] dside;

  rpi_div_pipe #(
    .QB_W (QB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_ctl   (ctl4_r),
    .in_den   (den4_r),
    .in_rem   (rem4_r),
    .in_sh    (sh4_r),
    .in_side  (side4_r),
    .out_ctl  (dctl),
    .out_q    (dq),
    .out_side (dside)
  );

  logic [QB-1:0]             tq;
  logic signed [COORD_W-1:0] dorg [3];
  logic signed [COORD_W-1:0] ddir [3];
  logic [COORD_W-1:0]        dmag [3];

  assign tq = dctl.ovf ? {QB{1'b1}} : dq;
  assign {dorg[0], dorg[1], dorg[2], ddir[0], ddir[1], ddir[2]} = dside;

  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign dmag[k] = ddir[k][COORD_W-1] ? COORD_W'(-ddir[k]) : COORD_W'(ddir[k]);
  end

  // Stage 5: split products of t and |dir|.
  ctl_t                      ctl5_r;
  logic [30:0]               t5_r;
  logic [HALF+31:0]          plo5_r [3];
  logic [QB-HALF+31:0]       phi5_r [3];
  logic                      neg5_r [3];
  logic signed [COORD_W-1:0] org5_r [3];

  // Stage 6: signed product.
  ctl_t                      ctl6_r;
  logic [30:0]               t6_r;
  logic signed [SW-1:0]      prod6_r [3];
  logic signed [COORD_W-1:0] org6_r [3];

  logic [MW-1:0]        mag6 [3];
  logic signed [XW-1:0] sum7 [3];
  logic [COORD_W-1:0]   sat7 [3];

  for (genvar k = 0; k < 3; k++) begin : g_pt
    assign mag6[k] = {phi5_r[k], {HALF{1'b0}}} + MW'(plo5_r[k]);
    // Arithmetic shift rounds toward minus infinity.
    assign sum7[k] = XW'(prod6_r[k] >>> FRAC_BITS) + XW'(org6_r[k]);
    always_comb begin
      if (sum7[k] > XW'(33'sh0_7fff_ffff)) begin
        sat7[k] = 32'h7fff_ffff;
      end else if (sum7[k] < -XW'(33'sh0_8000_0000)) begin
        sat7[k] = 32'h8000_0000;
      end else begin
        sat7[k] = sum7[k][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r      <= '0;
      ctl6_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      ctl5_r      <= dctl;
      ctl6_r      <= ctl5_r;
      out_valid_r <= ctl6_r.valid;
    end
  end

  logic        hit_r;
  logic [30:0] t_hit_r;
  logic [COORD_W-1:0] hp_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      t5_r <= (|tq[QB-1:31]) ? 31'h7fff_ffff : tq[30:0];
      t6_r <= t5_r;
      for (int k = 0; k < 3; k++) begin
        plo5_r[k]  <= tq[HALF-1:0] * dmag[k];
        phi5_r[k]  <= tq[QB-1:HALF] * dmag[k];
        neg5_r[k]  <= ddir[k][COORD_W-1];
        org5_r[k]  <= dorg[k];
        prod6_r[k] <= neg5_r[k] ? -$signed({1'b0, mag6[k]}) : $signed({1'b0, mag6[k]});
        org6_r[k]  <= org5_r[k];
        hp_r[k]    <= ctl6_r.hit ? sat7[k] : '0;
      end
      hit_r   <= ctl6_r.hit;
      t_hit_r <= ctl6_r.hit ? t6_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;
  assign out_t_hit = t_hit_r;
  assign out_hit_x = hp_r[0];
  assign out_hit_y = hp_r[1];
  assign out_hit_z = hp_r[2];

  // A miss must come out as all zeros.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_t_hit == '0 && out_hit_x == '0 &&
                              out_hit_y == '0 && out_hit_z == '0)
    else $error("miss result carries nonzero fields");

  // The input side is held back exactly when a result waits and out_stall is high.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the output stall");

  // Nothing leaves the block right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> !out_valid)
    else $error("result valid right after reset");

  // A result on hold keeps its hit flag while stalled.
  a_hold_hit: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) |-> $stable(out_hit) && out_valid)
    else $error("held result changed");

endmodule

/* bench/tb_ray_plane_intersection_top.sv */
// Self-checking testbench for ray_plane_intersection_top: rays against a configurable plane.
// Depends on rpi_pkg and the block's RTL; it predicts every result at full width.
`timescale 1ns / 100ps

module tb_ray_plane_intersection_top import rpi_pkg::*;;

  localparam int FB = 16;
  localparam int LATENCY = FB + 41;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct {
    logic signed [31:0] org[3];
    logic signed [31:0] dir[3];
  } ray_t;

  typedef struct {
    logic               hit;
    logic [30:0]        t_hit;
    logic signed [31:0] pos[3];
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic [30:0] out_t_hit;
  logic signed [31:0] out_hit_x, out_hit_y, out_hit_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Plane as the block should hold it.
  logic signed [31:0] plane_pt[3];
  logic signed [31:0] plane_nrm[3];

  hit_rec_t pending_hits[$];
  int fail_count = 0;
  int rays_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;

  ray_plane_intersection_top #(.FRAC_BITS(FB)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: a long hold when one is requested, random stalls otherwise.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  function automatic logic signed [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sh7fffffff) return CMAX;
    if (v < -128'sh80000000) return CMIN;
    return v[31:0];
  endfunction

  function automatic hit_rec_t predict_hit(ray_t r);
    logic signed [127:0] den, num, tq, p;
    hit_rec_t e;
    den = '0;
    num = '0;
    e.hit = 1'b0;
    e.t_hit = '0;
    for (int k = 0; k < 3; k++) begin
      e.pos[k] = '0;
      den = den + r.dir[k] * plane_nrm[k];
      num = num + (plane_pt[k] - r.org[k]) * plane_nrm[k];
    end
    if (den <= 0 || num < 0) return e;
    tq = (num <<< FB) / den;
    e.hit = 1'b1;
    e.t_hit = (tq > 128'sh7fffffff) ? 31'h7fffffff : tq[30:0];
    for (int k = 0; k < 3; k++) begin
      p = (tq * r.dir[k]) >>> FB;
      e.pos[k] = sat32(p + r.org[k]);
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    fail_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_hits.size() == 0) begin
        $display("Unexpected result at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        hit_rec_t e;
        e = pending_hits.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", 32'(out_hit), 32'(e.hit));
        if (out_t_hit !== e.t_hit)
          report_mismatch("t_hit", 32'(out_t_hit), 32'(e.t_hit));
        if (out_hit_x !== e.pos[0]) report_mismatch("hit_x", out_hit_x, e.pos[0]);
        if (out_hit_y !== e.pos[1]) report_mismatch("hit_y", out_hit_y, e.pos[1]);
        if (out_hit_z !== e.pos[2]) report_mismatch("hit_z", out_hit_z, e.pos[2]);
        if (e.hit) hits_seen++;
      end
      results_seen++;
    end
  end

  task automatic send_ray(ray_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 8) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_origin_x <= r.org[0];
    in_origin_y <= r.org[1];
    in_origin_z <= r.org[2];
    in_dir_x <= r.dir[0];
    in_dir_y <= r.dir[1];
    in_dir_z <= r.dir[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_hits.push_back(predict_hit(r));
    rays_sent++;
  endtask

  // Lowers the request line and waits until every result is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The block must be idle; consecutive writes keep cfg_valid high.
  task automatic write_reg(cfg_reg_t idx, logic signed [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_POINT_X || idx == REG_POINT_Y || idx == REG_POINT_Z)
      plane_pt[idx - REG_POINT_X] = value;
    else
      plane_nrm[idx - REG_NORMAL_X] = value;
  endtask

  task automatic set_plane(logic signed [31:0] px, py, pz, nx, ny, nz);
    write_reg(REG_POINT_X, px);
    write_reg(REG_POINT_Y, py);
    write_reg(REG_POINT_Z, pz);
    write_reg(REG_NORMAL_X, nx);
    write_reg(REG_NORMAL_Y, ny);
    write_reg(REG_NORMAL_Z, nz);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(4))
      0, 1: return $urandom();
      2: return $signed($urandom_range(8 << FB)) - (4 << FB);
      3: return $signed($urandom_range(1 << 22)) - (1 << 21);
      default: begin
        case ($urandom_range(4))
          0: return CMAX;
          1: return CMIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic ray_t make_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    return r;
  endfunction

  // Mostly rays that face the plane, so hits and their arithmetic dominate.
  function automatic ray_t rand_ray();
    ray_t r;
    logic signed [127:0] den;
    den = '0;
    for (int k = 0; k < 3; k++) begin
      r.org[k] = rand_coord();
      r.dir[k] = rand_coord();
      den = den + r.dir[k] * plane_nrm[k];
    end
    if (den < 0 && $urandom_range(3) != 0)
      for (int k = 0; k < 3; k++) r.dir[k] = -r.dir[k];
    return r;
  endfunction

  task automatic test_directed_reset_plane();
    send_ray(make_ray(0, 0, -ONE, 0, 0, ONE));          // plain hit at t = 1
    send_ray(make_ray(ONE, 2 * ONE, -4 * ONE, ONE, -ONE, 2 * ONE));
    send_ray(make_ray(0, 0, -ONE, ONE, ONE, 0));         // parallel: zero denominator
    send_ray(make_ray(0, 0, -ONE, 0, 0, -ONE));          // pointing away
    send_ray(make_ray(0, 0, ONE, 0, 0, ONE));            // plane behind the origin
    send_ray(make_ray(5, 7, 0, 3, 4, ONE));              // origin on the plane
    send_ray(make_ray(0, 0, CMIN, 0, 0, 1));             // t saturates
    send_ray(make_ray(CMAX, CMIN, CMIN, CMAX, CMIN, 1)); // hit point saturates
    send_ray(make_ray(CMIN, CMAX, -1, CMIN, CMAX, CMAX));
    send_ray(make_ray(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_ray(make_ray(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_ray(make_ray(-3, 9, -ONE / 3, -7, 11, 3));      // negative products floor
    drain();
  endtask

  task automatic test_extreme_planes();
    set_plane(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_ray(make_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
    send_ray(make_ray(CMAX, 0, 0, 1, 0, 0));
    send_ray(make_ray(0, 0, 0, CMAX, CMAX, CMAX));
    drain();
    set_plane(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_ray(make_ray(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_ray(make_ray(0, 0, 0, -1, 0, 0));
    send_ray(make_ray(CMIN, 0, CMAX, CMIN, CMAX, -1));
    drain();
    set_plane(0, 0, 0, 0, 0, 0);                         // no normal: every ray misses
    send_ray(make_ray(1, 2, 3, 4, 5, 6));
    drain();
  endtask

  task automatic test_random_rays(int count);
    repeat (count) send_ray(rand_ray());
  endtask

  task automatic test_random_planes(int planes, int rays_each);
    repeat (planes) begin
      drain();
      if ($urandom_range(1))
        set_plane(rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
      else
        set_plane($signed($urandom_range(8 << FB)) - (4 << FB), 0, 0,
                  $signed($urandom_range(2 << FB)) - ONE,
                  $signed($urandom_range(2 << FB)) - ONE, ONE);
      test_random_rays(rays_each);
    end
    drain();
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall the sender.
  task automatic test_backpressure();
    int saved_rx, saved_tx;
    saved_rx = rx_idle_pct;
    saved_tx = tx_idle_pct;
    rx_idle_pct = 0;
    tx_idle_pct = 0;
    @(negedge clk);
    hold_left = 3 * LATENCY;
    test_random_rays(2 * LATENCY);
    drain();
    rx_idle_pct = saved_rx;
    tx_idle_pct = saved_tx;
  endtask

  initial begin
    plane_pt = '{0, 0, 0};
    plane_nrm = '{0, 0, ONE};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 38;
    rx_idle_pct = 46;
    test_directed_reset_plane();
    test_extreme_planes();
    test_random_planes(4, 50);
    test_backpressure();

    tx_idle_pct = 46;
    rx_idle_pct = 38;
    test_random_planes(4, 50);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_planes(4, 50);
    test_random_rays(30);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d rays over extreme, reset and random planes; %0d results, %0d hits.",
             rays_sent, results_seen, hits_seen);
    $display("Idle patterns on both sides and a long receiver hold were exercised.");
    if (fail_count == 0 && pending_hits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* ray_plane_intersection_top.f */
rtl/rpi_pkg.sv
rtl/rpi_div_pipe.sv
rtl/ray_plane_intersection_top.sv
bench/tb_ray_plane_intersection_top.sv
